// ----- hw/rtl/tcw_pkg.sv -----
// Shared types, constants and helpers for the text console writer.
// Used by tcw_cell_ram, tcw_sequencer and text_console_writer; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Field widths (row holds ROWS itself while a scroll is pending)
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELL_W = $clog2(CELLS);
   localparam int IDX_W  = 11;
   localparam int DATA_W = 16;

   // Character codes
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   // Request kinds
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_SCROLL_LAST,
      ST_SCROLL_CLR,
      ST_PUT,
      ST_READ,
      ST_DONE
   } state_type;

   // One accepted request
   typedef struct packed {
      logic [1:0]       func;
      logic [7:0]       char_code;
      logic [7:0]       attribute;
      logic [IDX_W-1:0] cell_index;
   } req_type;

   // One result
   typedef struct packed {
      logic [7:0]       read_char;
      logic [7:0]       read_attribute;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_column;
      logic             scrolled;
   } rsp_type;

   // Cell store access: one write and one read address
   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [CELL_W-1:0] raddr;
   } mem_req_type;

   // Linear cell address of (row, column)
   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      cell_addr = CELL_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

// ----- hw/rtl/tcw_cell_ram.sv -----
// Character/attribute cell store: one write port, one registered read port.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cell_ram
   import tcw_pkg::*;
(
   input  logic                clock,
   input  mem_req_type         mem_req,
   output logic [DATA_W-1:0]   rd_data
);

   logic [DATA_W-1:0] mem [CELLS];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tcw_sequencer.sv -----
// Sequencer for the console: cursor state, scroll copy, clear sweep and cell
// read/write; the scroll copy and the clear sweeps share one cell counter. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_sequencer
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req,
   output mem_req_type         mem_req,
   input  logic [DATA_W-1:0]   rd_data,
   output logic                res_valid,
   input  logic                res_ready,
   output rsp_type             res
);

   localparam logic [CELL_W-1:0] LAST_CELL   = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] COPY_LAST   = CELL_W'(CELLS - COLUMNS - 1);
   localparam logic [CELL_W-1:0] ROW_OFFSET  = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] LAST_ROW_AT = CELL_W'(CELLS - COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_PEND    = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  cnt_ff, cnt_in;
   logic [CELL_W-1:0]  wptr_ff, wptr_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               scr_ff, scr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               zero_ff, zero_in;
   logic [7:0]         ch_ff, ch_in;
   logic [7:0]         attr_ff, attr_in;
   logic [DATA_W-1:0]  rd_ff, rd_in;
   logic [CELL_W-1:0]  cnt_next;
   logic [ROW_W-1:0]   bs_row;
   logic [COL_W-1:0]   bs_col;

   // shared counter step
   assign cnt_next = cnt_ff + 1'b1;

   // backspace target
   always_comb begin
      if (col_ff == '0) begin
         bs_row = row_ff - 1'b1;
         bs_col = COL_LAST;
      end else begin
         bs_row = row_ff;
         bs_col = col_ff - 1'b1;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         scr_ff     <= 1'b0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         scr_ff     <= scr_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wptr_ff <= wptr_in;
      zero_ff <= zero_in;
      ch_ff   <= ch_in;
      attr_ff <= attr_in;
      rd_ff   <= rd_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      wptr_in       = wptr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      scr_in        = scr_ff;
      clr_rsp_in    = clr_rsp_ff;
      zero_in       = zero_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      rd_in         = rd_ff;
      mem_req       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      unique case (state_ff)
         // zero sweep after reset or on a clear request
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_ff;
            cnt_in        = cnt_next;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready     = 1'b1;
            mem_req.raddr = (req.cell_index < IDX_W'(CELLS)) ?
                            CELL_W'(req.cell_index) : '0;
            if (req_valid) begin
               ch_in   = req.char_code;
               attr_in = req.attribute;
               zero_in = !(req.cell_index < IDX_W'(CELLS));
               rd_in   = '0;
               scr_in  = 1'b0;
               cnt_in  = '0;
               unique case (req.func)
                  FUNC_PUT:   state_in = (row_ff == ROW_PEND) ? ST_SCROLL : ST_PUT;
                  FUNC_READ:  state_in = ST_READ;
                  FUNC_CLEAR: begin
                     row_in     = '0;
                     col_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default:    state_in = ST_DONE;
               endcase
            end
         end

         // copy cell i+COLUMNS to cell i, read and write overlapped
         ST_SCROLL: begin
            mem_req.raddr = cnt_ff + ROW_OFFSET;
            mem_req.we    = (cnt_ff != '0);
            mem_req.waddr = wptr_ff;
            mem_req.wdata = rd_data;
            wptr_in       = cnt_ff;
            cnt_in        = cnt_next;
            if (cnt_ff == COPY_LAST) begin
               state_in = ST_SCROLL_LAST;
            end
         end

         ST_SCROLL_LAST: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wptr_ff;
            mem_req.wdata = rd_data;
            cnt_in        = LAST_ROW_AT;
            state_in      = ST_SCROLL_CLR;
         end

         // blank the bottom row
         ST_SCROLL_CLR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_ff;
            cnt_in        = cnt_next;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               row_in   = ROW_LAST;
               scr_in   = 1'b1;
               state_in = ST_PUT;
            end
         end

         // at most one cell write, and the cursor update
         ST_PUT: begin
            state_in = ST_DONE;
            if (ch_ff == CH_NEWLINE) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else if (ch_ff == CH_BACKSPACE) begin
               if (!(col_ff == '0 && row_ff == '0)) begin
                  row_in        = bs_row;
                  col_in        = bs_col;
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cell_addr(bs_row, bs_col);
               end
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cell_addr(row_ff, col_ff);
               mem_req.wdata = {attr_ff, ch_ff};
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end

         // read data is back from the store
         ST_READ: begin
            rd_in    = zero_ff ? '0 : rd_data;
            state_in = ST_DONE;
         end

         // hand the result to the output stage
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               clr_rsp_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign res.read_char      = rd_ff[7:0];
   assign res.read_attribute = rd_ff[15:8];
   assign res.cursor_row     = row_ff;
   assign res.cursor_column  = col_ff;
   assign res.scrolled       = scr_ff;

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// Text console writer top level: 80x25 cell store with cursor.
// A put goes through ST_PUT and ST_DONE, a read through ST_READ and ST_DONE, then the result
//   is registered at the output; a put at the scroll row first copies rows up and blanks the
//   bottom row, and a clear zeroes the store, one cell per cycle. One request is in flight
//   at a time and a held result stalls input. Reset: synchronous; the store is zeroed by a
//   sweep over all 2000 cells, with req_tready low. Depends on tcw_pkg, tcw_cell_ram, tcw_sequencer.
`timescale 1ns / 1ps

module text_console_writer
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        req_tlast,   // end_of_call
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // read_char[7:0], read_attribute[15:8], cursor_row[20:16],
                                    // cursor_column[27:21], scrolled[28]
);

   req_type            req;
   rsp_type            res;
   mem_req_type        mem_req;
   logic [DATA_W-1:0]  rd_data;
   logic               res_valid;
   logic               res_ready;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               unused_last;

   // request beat unpacking; the end-of-call mark carries no behavior
   assign req.func       = req_tuser;
   assign req.char_code  = req_tdata[7:0];
   assign req.attribute  = req_tdata[15:8];
   assign req.cell_index = req_tdata[26:16];
   assign unused_last    = req_tlast;

   tcw_cell_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   tcw_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register: loads when empty or draining
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, res.scrolled, res.cursor_column, res.cursor_row,
                         res.read_attribute, res.read_char} | {31'd0, 1'b0 & unused_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
